### hw/rtl/ibss_pkg.sv
// ----------------------------------------------------------------------------
// ibss_pkg
// Shared types and constants for the indexed byte sequence store.
// ----------------------------------------------------------------------------
`default_nettype none

package ibss_pkg;

    localparam int unsigned DEPTH_DEFAULT = 64;
    localparam int unsigned DATA_W        = 8;
    localparam int unsigned COUNT_OUT_W   = 7;

    typedef enum logic [2:0] {
        FUNC_INSERT = 3'd0,
        FUNC_DELETE = 3'd1,
        FUNC_READ   = 3'd2,
        FUNC_WRITE  = 3'd3,
        FUNC_CLEAR  = 3'd4
    } func_t;

    typedef enum logic [1:0] {
        STATUS_OK    = 2'd0,
        STATUS_RANGE = 2'd1,
        STATUS_FULL  = 2'd2,
        STATUS_EMPTY = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CELL_HOLD   = 2'd0,
        CELL_INSERT = 2'd1,
        CELL_DELETE = 2'd2,
        CELL_WRITE  = 2'd3
    } cell_op_t;

    typedef struct packed {
        cell_op_t            op;
        logic [DATA_W-1:0]   wdata;
    } cell_ctrl_t;

endpackage

`default_nettype wire

### hw/rtl/ibss_cell.sv
// ----------------------------------------------------------------------------
// ibss_cell
// One cell of the sequence: holds one byte, takes its left or right neighbor's
// byte on insert or delete, loads write data, and offers its byte for a read.
// ----------------------------------------------------------------------------
`default_nettype none

module ibss_cell
    import ibss_pkg::*;
#(
    parameter int unsigned AW    = 6,
    parameter int unsigned INDEX = 0
)
(
    input  wire logic              clk,
    input  wire cell_ctrl_t        ctrl,
    input  wire logic [AW-1:0]     sel,
    input  wire logic [DATA_W-1:0] left_data,
    input  wire logic [DATA_W-1:0] right_data,
    output logic      [DATA_W-1:0] data,
    output logic      [DATA_W-1:0] rd_data
);

    localparam logic [AW-1:0] MY_INDEX = AW'(INDEX);

    logic [DATA_W-1:0] data_reg;
    logic [DATA_W-1:0] data_next;
    logic              hit;
    logic              above;

    assign hit   = (sel == MY_INDEX);
    assign above = (MY_INDEX > sel);

    always_comb
    begin
        data_next = data_reg;
        unique case (ctrl.op)
            CELL_INSERT:
            begin
                if (above)
                    data_next = left_data;
                else if (hit)
                    data_next = ctrl.wdata;
            end
            CELL_DELETE:
            begin
                if (above || hit)
                    data_next = right_data;
            end
            CELL_WRITE:
            begin
                if (hit)
                    data_next = ctrl.wdata;
            end
            default:
            begin
                data_next = data_reg;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
    end

    assign data    = data_reg;
    assign rd_data = hit ? data_reg : '0;

endmodule

`default_nettype wire

### hw/rtl/indexed_byte_sequence_store.sv
// ----------------------------------------------------------------------------
// indexed_byte_sequence_store
// Ordered byte sequence of up to DEPTH entries with insert, delete, read,
// write and clear by position, built as a row of shifting cells.
// ----------------------------------------------------------------------------
// The result strobe done rises in the cycle after start is taken.
// Throughput: one request per cycle; every cell shifts or loads in parallel,
// so busy stays low and the whole row of cells updates at once.
// Reset: rst_n clears the count and the result strobe; cell contents are
// left as they are and are never read before an insert writes them.
`default_nettype none

module indexed_byte_sequence_store
    import ibss_pkg::*;
#(
    parameter int unsigned DEPTH = DEPTH_DEFAULT
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   start,
    output logic                        busy,
    input  wire logic [2:0]             func,
    input  wire logic signed [7:0]      position,
    input  wire logic [DATA_W-1:0]      write_value,
    output logic                        done,
    output logic [DATA_W-1:0]           read_value,
    output logic [COUNT_OUT_W-1:0]      element_count,
    output logic [1:0]                  status
);

    localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int unsigned CW = $clog2(DEPTH + 1);
    localparam int unsigned PW = CW + 8;
    localparam logic [CW-1:0] FULL_COUNT = CW'(DEPTH);

    logic                   accept;
    logic [CW-1:0]          count_reg;
    logic [CW-1:0]          count_next;
    logic                   done_reg;
    logic [DATA_W-1:0]      read_value_reg;
    logic [DATA_W-1:0]      read_value_next;
    status_t                status_reg;
    status_t                status_next;

    cell_ctrl_t             ctrl;
    logic [AW-1:0]          sel;
    logic                   rd_en;
    logic [DATA_W-1:0]      rd_or;

    logic [PW-1:0]          pos_w;
    logic [PW-1:0]          n_w;
    logic [PW-1:0]          n_m1_w;
    logic [PW-1:0]          ins_p;
    logic [PW-1:0]          del_p;
    logic                   pos_nonpos;
    logic                   in_range;
    logic [CW+COUNT_OUT_W-1:0] count_ext;

    logic [DATA_W-1:0]      cell_data [DEPTH];
    logic [DATA_W-1:0]      cell_rd   [DEPTH];

    assign busy   = 1'b0;
    assign accept = start && !busy;

    assign pos_w      = PW'(position[6:0]);
    assign n_w        = PW'(count_reg);
    assign n_m1_w     = PW'(count_reg - 1'b1);
    assign pos_nonpos = position[7] || (position == 8'sd0);
    assign in_range   = !position[7] && (pos_w < n_w);
    assign ins_p      = pos_nonpos ? '0 : ((pos_w >= n_w) ? n_w : pos_w);
    assign del_p      = pos_nonpos ? '0 : ((pos_w >= n_m1_w) ? n_m1_w : pos_w);

    always_comb
    begin
        ctrl.op     = CELL_HOLD;
        ctrl.wdata  = write_value;
        sel         = pos_w[AW-1:0];
        rd_en       = 1'b0;
        count_next  = count_reg;
        status_next = STATUS_OK;
        if (accept)
        begin
            unique case (func) inside
                FUNC_INSERT:
                begin
                    if (count_reg == FULL_COUNT)
                        status_next = STATUS_FULL;
                    else
                    begin
                        ctrl.op    = CELL_INSERT;
                        sel        = ins_p[AW-1:0];
                        count_next = count_reg + 1'b1;
                    end
                end
                FUNC_DELETE:
                begin
                    if (count_reg == '0)
                        status_next = STATUS_EMPTY;
                    else
                    begin
                        ctrl.op    = CELL_DELETE;
                        sel        = del_p[AW-1:0];
                        count_next = count_reg - 1'b1;
                    end
                end
                FUNC_READ, FUNC_WRITE:
                begin
                    if (!in_range)
                        status_next = STATUS_RANGE;
                    else if (func == FUNC_READ)
                        rd_en = 1'b1;
                    else
                        ctrl.op = CELL_WRITE;
                end
                FUNC_CLEAR:
                begin
                    count_next = '0;
                end
                default:
                begin
                    status_next = STATUS_OK;
                end
            endcase
        end
    end

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [DATA_W-1:0] left_d;
        logic [DATA_W-1:0] right_d;

        if (i == 0)
        begin : g_first
            assign left_d = '0;
        end
        else
        begin : g_mid_l
            assign left_d = cell_data[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_d = '0;
        end
        else
        begin : g_mid_r
            assign right_d = cell_data[i+1];
        end

        ibss_cell #(
            .AW    (AW),
            .INDEX (i)
        ) u_cell (
            .clk        (clk),
            .ctrl       (ctrl),
            .sel        (sel),
            .left_data  (left_d),
            .right_data (right_d),
            .data       (cell_data[i]),
            .rd_data    (cell_rd[i])
        );
    end

    always_comb
    begin
        rd_or = '0;
        for (int i = 0; i < DEPTH; i++)
            rd_or = rd_or | cell_rd[i];
    end

    assign read_value_next = rd_en ? rd_or : '0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        read_value_reg <= read_value_next;
        status_reg     <= status_next;
    end

    assign count_ext     = {{COUNT_OUT_W{1'b0}}, count_reg};
    assign done          = done_reg;
    assign read_value    = read_value_reg;
    assign element_count = count_ext[COUNT_OUT_W-1:0];
    assign status        = status_reg;

`ifndef SYNTHESIS
    a_done_follows_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> done)
        else $error("transfer accepted without a result strobe");

    a_count_bounded: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= FULL_COUNT)
        else $error("count exceeds depth");

    a_insert_grows: assert property (@(posedge clk) disable iff (!rst_n)
        (accept && func == FUNC_INSERT && count_reg != FULL_COUNT)
        |=> count_reg == $past(count_reg) + 1'b1)
        else $error("insert did not advance count");

    a_full_status: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status_reg == STATUS_FULL) |-> count_reg == FULL_COUNT)
        else $error("full status with room left");

    a_idle_holds_count: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(count_reg))
        else $error("count changed without a transfer");
`endif

endmodule

`default_nettype wire
